### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property on i_clk, disabled while i_rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### sv/bkct_pkg.sv
// types, constants and codes of the bounded keyed count table
package bkct_pkg;

    localparam int MAX_SLOTS_DEF = 64;

    localparam int KEY_W   = 16;
    localparam int AMT_W   = 16;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 7;
    localparam int SLOTS_W = 7;
    localparam int STS_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    // stream packing
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_MOVED_LSB = 0;
    localparam int OUT_STS_LSB   = OUT_MOVED_LSB + AMT_W;
    localparam int OUT_SLOTS_LSB = OUT_STS_LSB + STS_W;
    localparam int OUT_USED_W    = OUT_SLOTS_LSB + SLOTS_W;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [STS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_INVALID   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB_MIN
    } t_alu_op;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             key_ge;
        logic             key_eq;
        logic [AMT_W-1:0] moved;
        logic [CNT_W-1:0] new_count;
        logic             zero;
    } t_alu_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MISS,
        ST_SHU_RD,
        ST_SHU_WR,
        ST_INS,
        ST_SHD_RD,
        ST_SHD_WR,
        ST_RESP
    } t_state;

endpackage

### sv/bounded_keyed_count_table_unit.sv
// top level of the bounded keyed count table
//
// usage
//   s_axis carries one request per beat: tuser is the command (0 insert,
//   1 extract), tdata holds the key in bits 15:0 and the amount in 31:16.
//   m_axis returns one result beat per request: moved, status, slots used.
//   the cfg channel writes slot_capacity; it is always ready and should
//   only be written while no request is in flight.
// sequencing
//   one request at a time; s_axis_tready is high only while idle.
//   a key or amount of zero goes straight to the response state, which
//   loads the result beat.  otherwise the table is scanned in key order,
//   a read state and a check state per entry visited, and an insert of a
//   new key or an extract that empties an entry shifts the entries beyond
//   it, a read state and a write state per entry.
// reset and stalls
//   i_rst_n low empties the table and sets slot_capacity to 8; the ram is
//   not cleared.  a stalled result waits in the output register while the
//   next request is taken, and that one waits in the sequencer.
module bounded_keyed_count_table_unit #(
    parameter int MAX_SLOTS = bkct_pkg::MAX_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request beat
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bkct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // item_key, amount
    input  logic                               s_axis_tuser,  // cmd
    // result beat
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bkct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // moved, status, slots_used, pad
    // capacity register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bkct_pkg::CAP_W-1:0]         i_cfg_data
);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OW = $clog2(MAX_SLOTS + 1);
    localparam int EW = $bits(bkct_pkg::t_entry);

    bkct_pkg::t_state r_state, n_state;

    // latched request
    logic                        r_cmd;
    logic [bkct_pkg::KEY_W-1:0]  r_key;
    logic [bkct_pkg::AMT_W-1:0]  r_amt;

    logic [AW-1:0]               r_idx, n_idx;
    logic [OW-1:0]               r_pos, n_pos;
    logic [OW-1:0]               r_occ, n_occ;
    logic [bkct_pkg::AMT_W-1:0]  r_moved, n_moved;
    bkct_pkg::t_status           r_status, n_status;
    logic [bkct_pkg::CAP_W-1:0]  r_cap;

    logic                                r_out_valid;
    logic [bkct_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                                load_out;

    logic                        in_beat;
    logic [bkct_pkg::KEY_W-1:0]  in_key;
    logic [bkct_pkg::AMT_W-1:0]  in_amt;
    logic                        table_full;

    // table ram
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    bkct_pkg::t_entry            ram_wdata;
    bkct_pkg::t_entry            ram_rdata;
    logic [EW-1:0]               ram_rdata_raw;

    bkct_pkg::t_alu_op           alu_op;
    bkct_pkg::t_alu_res          alu_res;

    assign in_key = s_axis_tdata[bkct_pkg::KEY_W-1:0];
    assign in_amt = s_axis_tdata[bkct_pkg::KEY_W +: bkct_pkg::AMT_W];

    assign s_axis_tready = (r_state == bkct_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // effective capacity is the smaller of the register and the table depth
    assign table_full = (32'(r_occ) >= 32'(r_cap)) || (32'(r_occ) >= 32'(MAX_SLOTS));

    assign alu_op    = (r_cmd == bkct_pkg::CMD_EXTRACT) ? bkct_pkg::ALU_SUB_MIN
                                                        : bkct_pkg::ALU_ADD_SAT;
    assign ram_rdata = bkct_pkg::t_entry'(ram_rdata_raw);

    bkct_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    bkct_alu u_alu (
        .i_op    (alu_op),
        .i_entry (ram_rdata),
        .i_key   (r_key),
        .i_amt   (r_amt),
        .o_res   (alu_res)
    );

    // sequencer state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bkct_pkg::ST_IDLE;
            r_occ   <= '0;
            r_cap   <= bkct_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // request payload and scratch values need no reset
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cmd <= s_axis_tuser;
            r_key <= in_key;
            r_amt <= in_amt;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_moved  <= n_moved;
        r_status <= n_status;
    end

    // output register: holds a result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= bkct_pkg::OUT_TDATA_W'({
                bkct_pkg::SLOTS_W'(r_occ), r_status, r_moved});
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_occ     = r_occ;
        n_moved   = r_moved;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_raddr = r_idx;
        ram_wdata = ram_rdata;
        load_out  = 1'b0;

        unique case (r_state)
            bkct_pkg::ST_IDLE: begin
                n_moved  = '0;
                n_status = bkct_pkg::STS_DONE;
                if (in_beat) begin
                    priority if (in_key == '0 || in_amt == '0) begin
                        n_status = bkct_pkg::STS_INVALID;
                        n_state  = bkct_pkg::ST_RESP;
                    end else if (r_occ == '0) begin
                        n_pos   = '0;
                        n_state = bkct_pkg::ST_MISS;
                    end else begin
                        n_idx   = '0;
                        n_state = bkct_pkg::ST_SCAN_RD;
                    end
                end
            end

            bkct_pkg::ST_SCAN_RD: begin
                ram_raddr = r_idx;
                n_state   = bkct_pkg::ST_SCAN_CHK;
            end

            bkct_pkg::ST_SCAN_CHK: begin
                priority if (alu_res.key_ge && alu_res.key_eq) begin
                    // key present: update in place or remove
                    n_moved         = alu_res.moved;
                    ram_waddr       = r_idx;
                    ram_wdata.key   = ram_rdata.key;
                    ram_wdata.count = alu_res.new_count;
                    priority if (r_cmd == bkct_pkg::CMD_INSERT || !alu_res.zero) begin
                        ram_we  = 1'b1;
                        n_state = bkct_pkg::ST_RESP;
                    end else if (OW'(r_idx) + OW'(1) < r_occ) begin
                        n_state = bkct_pkg::ST_SHD_RD;
                    end else begin
                        n_occ   = r_occ - OW'(1);
                        n_state = bkct_pkg::ST_RESP;
                    end
                end else if (alu_res.key_ge) begin
                    n_pos   = OW'(r_idx);
                    n_state = bkct_pkg::ST_MISS;
                end else if (OW'(r_idx) + OW'(1) == r_occ) begin
                    n_pos   = r_occ;
                    n_state = bkct_pkg::ST_MISS;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = bkct_pkg::ST_SCAN_RD;
                end
            end

            bkct_pkg::ST_MISS: begin
                priority if (r_cmd == bkct_pkg::CMD_EXTRACT) begin
                    n_status = bkct_pkg::STS_NOT_FOUND;
                    n_state  = bkct_pkg::ST_RESP;
                end else if (table_full) begin
                    n_status = bkct_pkg::STS_FULL;
                    n_state  = bkct_pkg::ST_RESP;
                end else if (r_pos == r_occ) begin
                    n_state = bkct_pkg::ST_INS;
                end else begin
                    // open a gap at r_pos, moving from the top down
                    n_idx   = AW'(r_occ);
                    n_state = bkct_pkg::ST_SHU_RD;
                end
            end

            bkct_pkg::ST_SHU_RD: begin
                ram_raddr = r_idx - AW'(1);
                n_state   = bkct_pkg::ST_SHU_WR;
            end

            bkct_pkg::ST_SHU_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = r_idx - AW'(1);
                if (OW'(r_idx - AW'(1)) == r_pos) begin
                    n_state = bkct_pkg::ST_INS;
                end else begin
                    n_state = bkct_pkg::ST_SHU_RD;
                end
            end

            bkct_pkg::ST_INS: begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(r_pos);
                ram_wdata.key   = r_key;
                ram_wdata.count = bkct_pkg::CNT_W'(r_amt);
                n_occ           = r_occ + OW'(1);
                n_moved         = r_amt;
                n_state         = bkct_pkg::ST_RESP;
            end

            bkct_pkg::ST_SHD_RD: begin
                ram_raddr = r_idx + AW'(1);
                n_state   = bkct_pkg::ST_SHD_WR;
            end

            bkct_pkg::ST_SHD_WR: begin
                // close the gap left by a removed entry
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + AW'(1);
                if (OW'(r_idx) + OW'(2) < r_occ) begin
                    n_state = bkct_pkg::ST_SHD_RD;
                end else begin
                    n_occ   = r_occ - OW'(1);
                    n_state = bkct_pkg::ST_RESP;
                end
            end

            bkct_pkg::ST_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = bkct_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bkct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/bkct_ram.sv
// generic single write port ram with registered read
module bkct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_W-1:0]    i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bkct_alu.sv
// shared key compare and saturating add / clamped subtract unit
module bkct_alu (
    input  bkct_pkg::t_alu_op                 i_op,
    input  bkct_pkg::t_entry                  i_entry,
    input  logic [bkct_pkg::KEY_W-1:0]        i_key,
    input  logic [bkct_pkg::AMT_W-1:0]        i_amt,
    output bkct_pkg::t_alu_res                o_res
);
    logic [bkct_pkg::CNT_W-1:0] limit;
    logic [bkct_pkg::CNT_W-1:0] amt_ext;
    logic [bkct_pkg::CNT_W-1:0] step;
    logic [bkct_pkg::CNT_W-1:0] result;

    always_comb begin
        amt_ext = bkct_pkg::CNT_W'(i_amt);
        // headroom for add, stored count for subtract
        limit   = (i_op == bkct_pkg::ALU_ADD_SAT) ? ~i_entry.count : i_entry.count;
        step    = (limit < amt_ext) ? limit : amt_ext;
        result  = (i_op == bkct_pkg::ALU_ADD_SAT) ? i_entry.count + step
                                                  : i_entry.count - step;
        o_res.key_ge    = i_entry.key >= i_key;
        o_res.key_eq    = i_entry.key == i_key;
        o_res.moved     = step[bkct_pkg::AMT_W-1:0];
        o_res.new_count = result;
        o_res.zero      = result == '0;
    end

endmodule

### sv/bkct_chk.sv
// port level checks of the bounded keyed count table
`include "assert_macros.svh"

module bkct_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [bkct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    logic [bkct_pkg::STS_W-1:0] out_status;
    logic [bkct_pkg::AMT_W-1:0] out_moved;

    assign out_status = m_axis_tdata[bkct_pkg::OUT_STS_LSB +: bkct_pkg::STS_W];
    assign out_moved  = m_axis_tdata[bkct_pkg::OUT_MOVED_LSB +: bkct_pkg::AMT_W];

    // a stalled result beat stays put
    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // one request in flight: ready drops after every accepted beat
    `ASSERT_CLK(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")

    // a refused request never reports a moved quantity
    `ASSERT_NEVER(a_refused_moves, m_axis_tvalid && out_status != bkct_pkg::STS_DONE && out_moved != '0, "refused request with nonzero moved")

endmodule

bind bounded_keyed_count_table_unit bkct_chk u_bkct_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
